// File: src/assert_macros.svh
// Assertion macros for the module that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SBP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/sbp_pkg.sv
// Types and constants of the sparse boolean product rows unit.
package sbp_pkg;

    localparam int ELEM_W = 10;
    localparam int FACE_W = 10;
    localparam int EDGE_W = 12;
    localparam int POS_W  = 15;
    localparam int CAP_W  = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 16'h8000;

    typedef enum logic
    {
        KIND_LOAD    = 1'b0,
        KIND_PRODUCT = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t              kind;
        logic [ELEM_W-1:0]  elem;
        logic [FACE_W-1:0]  face;
        logic [EDGE_W-1:0]  edge_id;
    } item_t;

    typedef struct packed
    {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_COUNT,
        ST_WALK,
        ST_FLUSH
    } back_state_t;

endpackage

// File: src/sbp_front.sv
// Front part: accepts input beats, drops out-of-range items and classifies the rest.
module sbp_front #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int MAX_FACES    = 1024,
    parameter int MAX_EDGES    = 4096
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // element_index, face_index, edge_index
    input  logic                  s_tuser,   // command
    input  sbp_pkg::back_status_t status,
    output logic                  f_valid,
    output sbp_pkg::item_t        f_item,
    input  logic                  f_ready
);

    logic           valid_reg, valid_next;
    sbp_pkg::item_t item_reg, item_next;
    logic           accept, keep, push;
    logic [9:0]     elem, face;
    logic [11:0]    edge_id;

    assign elem    = s_tdata[9:0];
    assign face    = s_tdata[19:10];
    assign edge_id = s_tdata[31:20];
    assign push    = valid_reg && f_ready;
    assign s_tready = !status.clearing && (!valid_reg || f_ready);
    assign accept  = s_tvalid && s_tready;

    always_comb
    begin
        item_next.kind    = sbp_pkg::kind_t'(s_tuser);
        item_next.elem    = elem;
        item_next.face    = face;
        item_next.edge_id = edge_id;
        if (s_tuser == sbp_pkg::KIND_PRODUCT)
        begin
            keep = (32'(elem) < MAX_ELEMENTS) && (32'(face) < MAX_FACES);
        end
        else
        begin
            keep = (32'(face) < MAX_FACES) && (32'(edge_id) < MAX_EDGES);
        end
        if (accept && keep)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            item_reg <= item_next;
        end
    end

    assign f_valid = valid_reg;
    assign f_item  = item_reg;

endmodule

// File: src/sbp_queue.sv
// Two-entry queue that decouples the front part from the back part.
module sbp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  sbp_pkg::item_t in_item,
    output logic           in_ready,
    output logic           out_valid,
    output sbp_pkg::item_t out_item,
    input  logic           out_pop
);

    sbp_pkg::item_t slot_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           do_push, do_pop;

    assign in_ready  = (fill_reg != 2'd2);
    assign out_valid = (fill_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign do_push   = in_valid && in_ready;
    assign do_pop    = out_pop && out_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        fill_next   = fill_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: src/sbp_back.sv
// Back part: face edge store, edge stamps and the walk that produces result beats.
module sbp_back #(
    parameter int MAX_ELEMENTS       = 1024,
    parameter int MAX_FACES          = 1024,
    parameter int MAX_EDGES          = 4096,
    parameter int MAX_EDGES_PER_FACE = 16,
    parameter int MAX_OUTPUT         = 32768
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  sbp_pkg::item_t        q_item,
    output logic                  q_pop,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [39:0]           m_tdata,
    output logic                  m_tlast,
    output logic                  m_tuser,
    output sbp_pkg::back_status_t status
);

    localparam int FW    = $clog2(MAX_FACES);
    localparam int EW    = $clog2(MAX_EDGES);
    localparam int SW    = $clog2(MAX_ELEMENTS + 1);
    localparam int CNW   = $clog2(MAX_EDGES_PER_FACE + 1);
    localparam int TAW   = $clog2(MAX_FACES * MAX_EDGES_PER_FACE);
    localparam int OCW   = $clog2(MAX_OUTPUT + 1);
    localparam int CLR_N = (MAX_FACES > MAX_EDGES) ? MAX_FACES : MAX_EDGES;
    localparam int CLRW  = $clog2(CLR_N);
    localparam int TBL_N = MAX_FACES * MAX_EDGES_PER_FACE;

    localparam int EL_W = sbp_pkg::ELEM_W;
    localparam int ED_W = sbp_pkg::EDGE_W;
    localparam int PS_W = sbp_pkg::POS_W;

    // Memories
    logic [ED_W-1:0] tbl_mem [TBL_N];
    logic [CNW-1:0]  cnt_mem [MAX_FACES];
    logic [SW-1:0]   stamp_mem [MAX_EDGES];

    logic [ED_W-1:0] tbl_q;
    logic [CNW-1:0]  cnt_q;
    logic [SW-1:0]   stamp_q;

    logic            tbl_we, cnt_we, stamp_we, rd_en;
    logic [TAW-1:0]  tbl_waddr, tbl_raddr;
    logic [ED_W-1:0] tbl_wdata;
    logic [FW-1:0]   cnt_waddr, cnt_raddr;
    logic [CNW-1:0]  cnt_wdata;
    logic [EW-1:0]   stamp_waddr, stamp_raddr;
    logic [SW-1:0]   stamp_wdata;

    sbp_pkg::back_state_t state_reg, state_next;
    logic [CLRW-1:0]        clr_reg, clr_next;
    sbp_pkg::item_t         item_reg, item_next;
    logic [CNW-1:0]         len_reg, len_next;
    logic [CNW-1:0]         idx_reg, idx_next;
    logic [TAW-1:0]         base_reg, base_next;
    logic                   t_valid_reg, t_valid_next;
    logic                   s_valid_reg, s_valid_next;
    logic [ED_W-1:0]        s_edge_reg, s_edge_next;
    logic                   lw_valid_reg, lw_valid_next;
    logic [ED_W-1:0]        lw_edge_reg, lw_edge_next;
    logic [OCW-1:0]         ocnt_reg, ocnt_next;
    logic [15:0]            cap_reg;

    logic                   pend_valid_reg, pend_valid_next;
    logic [ED_W-1:0]        pend_edge_reg, pend_edge_next;
    logic [PS_W-1:0]        pend_pos_reg, pend_pos_next;
    logic                   pend_ovf_reg, pend_ovf_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;
    logic [ED_W-1:0]        out_edge_reg;
    logic [PS_W-1:0]        out_pos_reg;
    logic                   out_ovf_reg, out_last_reg, out_last_next;
    logic [EL_W-1:0]        out_elem_reg;

    logic                   out_free, adv, issue;
    logic                   in_range, hit, is_new, is_ovf;
    logic [31:0]            cap_eff;
    logic [SW-1:0]          cur_stamp;

    assign out_free  = !out_valid_reg || m_tready;
    assign cap_eff   = (32'(cap_reg) < MAX_OUTPUT) ? 32'(cap_reg) : MAX_OUTPUT;
    assign cur_stamp = SW'(item_reg.elem) + SW'(1);
    assign in_range  = 32'(s_edge_reg) < MAX_EDGES;
    assign hit       = (stamp_q == cur_stamp) || (lw_valid_reg && (lw_edge_reg == s_edge_reg));
    assign is_new    = s_valid_reg && in_range && !hit;
    assign is_ovf    = 32'(ocnt_reg) >= cap_eff;
    assign issue     = idx_reg < len_reg;

    assign cnt_raddr   = FW'(q_item.face);
    assign tbl_raddr   = base_reg + TAW'(idx_reg);
    assign stamp_raddr = EW'(tbl_q);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        item_next       = item_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        base_next       = base_reg;
        t_valid_next    = t_valid_reg;
        s_valid_next    = s_valid_reg;
        s_edge_next     = s_edge_reg;
        lw_valid_next   = lw_valid_reg;
        lw_edge_next    = lw_edge_reg;
        ocnt_next       = ocnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_edge_next  = pend_edge_reg;
        pend_pos_next   = pend_pos_reg;
        pend_ovf_next   = pend_ovf_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_load        = 1'b0;
        out_last_next   = 1'b0;
        q_pop           = 1'b0;
        rd_en           = 1'b1;
        adv             = 1'b1;
        tbl_we          = 1'b0;
        tbl_waddr       = TAW'(item_reg.face) * TAW'(MAX_EDGES_PER_FACE) + TAW'(cnt_q);
        tbl_wdata       = item_reg.edge_id;
        cnt_we          = 1'b0;
        cnt_waddr       = FW'(item_reg.face);
        cnt_wdata       = cnt_q + CNW'(1);
        stamp_we        = 1'b0;
        stamp_waddr     = EW'(s_edge_reg);
        stamp_wdata     = cur_stamp;

        unique case (state_reg)
            sbp_pkg::ST_CLEAR:
            begin
                // One entry of each of the count and stamp stores per cycle back to its reset value.
                cnt_we      = 32'(clr_reg) < MAX_FACES;
                cnt_waddr   = FW'(clr_reg);
                cnt_wdata   = '0;
                stamp_we    = 32'(clr_reg) < MAX_EDGES;
                stamp_waddr = EW'(clr_reg);
                stamp_wdata = '0;
                clr_next    = clr_reg + CLRW'(1);
                if (32'(clr_reg) == CLR_N - 1)
                begin
                    state_next = sbp_pkg::ST_IDLE;
                end
            end
            sbp_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop     = 1'b1;
                    item_next = q_item;
                    if (q_item.kind == sbp_pkg::KIND_PRODUCT)
                    begin
                        state_next = sbp_pkg::ST_COUNT;
                    end
                    else
                    begin
                        state_next = sbp_pkg::ST_LOAD;
                    end
                end
            end
            sbp_pkg::ST_LOAD:
            begin
                if (32'(cnt_q) < MAX_EDGES_PER_FACE)
                begin
                    tbl_we = 1'b1;
                    cnt_we = 1'b1;
                end
                state_next = sbp_pkg::ST_IDLE;
            end
            sbp_pkg::ST_COUNT:
            begin
                len_next      = cnt_q;
                idx_next      = '0;
                base_next     = TAW'(item_reg.face) * TAW'(MAX_EDGES_PER_FACE);
                t_valid_next  = 1'b0;
                s_valid_next  = 1'b0;
                lw_valid_next = 1'b0;
                state_next    = sbp_pkg::ST_WALK;
            end
            sbp_pkg::ST_WALK:
            begin
                // The walk holds while a found edge cannot displace the pending one.
                if (is_new && pend_valid_reg && !out_free)
                begin
                    adv = 1'b0;
                end
                rd_en = adv;
                if (adv)
                begin
                    t_valid_next  = issue;
                    idx_next      = idx_reg + CNW'(issue);
                    s_valid_next  = t_valid_reg;
                    s_edge_next   = tbl_q;
                    lw_valid_next = 1'b0;
                    if (is_new)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load       = 1'b1;
                            out_valid_next = 1'b1;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_edge_next  = s_edge_reg;
                        pend_ovf_next   = is_ovf;
                        if (is_ovf)
                        begin
                            pend_pos_next = '0;
                            t_valid_next  = 1'b0;
                            s_valid_next  = 1'b0;
                            state_next    = sbp_pkg::ST_FLUSH;
                        end
                        else
                        begin
                            pend_pos_next = PS_W'(ocnt_reg);
                            stamp_we      = 1'b1;
                            ocnt_next     = ocnt_reg + OCW'(1);
                            lw_valid_next = 1'b1;
                            lw_edge_next  = s_edge_reg;
                        end
                    end
                    else if (!t_valid_reg && !s_valid_reg && !issue)
                    begin
                        state_next = sbp_pkg::ST_FLUSH;
                    end
                end
                else
                begin
                    lw_valid_next = lw_valid_reg;
                end
            end
            sbp_pkg::ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = sbp_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = sbp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sbp_pkg::ST_CLEAR;
            clr_reg        <= '0;
            t_valid_reg    <= 1'b0;
            s_valid_reg    <= 1'b0;
            lw_valid_reg   <= 1'b0;
            ocnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            cap_reg        <= sbp_pkg::CAP_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            t_valid_reg    <= t_valid_next;
            s_valid_reg    <= s_valid_next;
            lw_valid_reg   <= lw_valid_next;
            ocnt_reg       <= ocnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        len_reg       <= len_next;
        idx_reg       <= idx_next;
        base_reg      <= base_next;
        s_edge_reg    <= s_edge_next;
        lw_edge_reg   <= lw_edge_next;
        pend_edge_reg <= pend_edge_next;
        pend_pos_reg  <= pend_pos_next;
        pend_ovf_reg  <= pend_ovf_next;
        if (out_load)
        begin
            out_elem_reg <= item_reg.elem;
            out_edge_reg <= pend_edge_reg;
            out_pos_reg  <= pend_pos_reg;
            out_ovf_reg  <= pend_ovf_reg;
            out_last_reg <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (rd_en)
        begin
            tbl_q <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_q <= cnt_mem[cnt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= stamp_wdata;
        end
        if (rd_en)
        begin
            stamp_q <= stamp_mem[stamp_raddr];
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign m_tdata         = {3'b000, out_pos_reg, out_edge_reg, out_elem_reg};
    assign m_tlast         = out_last_reg;
    assign m_tuser         = out_ovf_reg;
    assign status.clearing = (state_reg == sbp_pkg::ST_CLEAR);

endmodule

// File: src/sparse_boolean_product_rows_unit.sv
// A product item's result beats leave as the walk finds them: each new edge is held pending and
// offered when the next one displaces it, the last one when the walk ends. The back part takes
// the next queued item only when idle again; the walk reads one face table entry and one edge
// stamp per cycle through the back part's read/check/write pipeline while results can leave.
// Reset (rst_n, asynchronous, active low) clears control state, then a clearing pass resets face
// counts and edge stamps; no beat is taken meanwhile, configuration writes are.
`include "assert_macros.svh"
module sparse_boolean_product_rows_unit #(
    parameter int MAX_ELEMENTS       = 1024,
    parameter int MAX_FACES          = 1024,
    parameter int MAX_EDGES          = 4096,
    parameter int MAX_EDGES_PER_FACE = 16,
    parameter int MAX_OUTPUT         = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // element_index, face_index, edge_index
    input  logic        s_tuser,     // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,     // row_element, column_edge, position, zero pad
    output logic        m_tlast,     // last_of_run
    output logic        m_tuser,     // overflow
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data  // output_capacity
);

    sbp_pkg::back_status_t status;
    logic                  f_valid, f_ready, q_valid, q_pop;
    sbp_pkg::item_t        f_item, q_item;

    sbp_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .MAX_FACES    (MAX_FACES),
        .MAX_EDGES    (MAX_EDGES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .status   (status),
        .f_valid  (f_valid),
        .f_item   (f_item),
        .f_ready  (f_ready)
    );

    sbp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_item   (f_item),
        .in_ready  (f_ready),
        .out_valid (q_valid),
        .out_item  (q_item),
        .out_pop   (q_pop)
    );

    sbp_back #(
        .MAX_ELEMENTS       (MAX_ELEMENTS),
        .MAX_FACES          (MAX_FACES),
        .MAX_EDGES          (MAX_EDGES),
        .MAX_EDGES_PER_FACE (MAX_EDGES_PER_FACE),
        .MAX_OUTPUT         (MAX_OUTPUT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .status      (status)
    );

    // No input beat may be taken while the stores are being cleared.
    `SBP_ASSERT_IMP(a_no_accept_clear, clk, rst_n, status.clearing, !s_tready)
    // An overflow beat always closes its run and carries position zero.
    `SBP_ASSERT_IMP(a_ovf_beat, clk, rst_n, m_tvalid && m_tuser, m_tlast && (m_tdata[36:22] == 15'd0))
    // A queue pop only happens when the queue holds an item.
    `SBP_ASSERT_IMP(a_pop_valid, clk, rst_n, q_pop, q_valid)

endmodule
